// ===== src/kruskal_edge_filter_top_macros.svh =====
// Assertion macros for the spanning-tree edge filter.
// Each check samples on the rising edge of clk and is disabled while rst is high.
`ifndef KRUSKAL_EDGE_FILTER_TOP_MACROS_SVH
`define KRUSKAL_EDGE_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define KEF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edge filter check failed");
`define KEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edge filter check failed");
`else
`define KEF_ASSERT_SAME(lbl, ante, cons)
`define KEF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/kef_pkg.sv =====
package kef_pkg;

  localparam int VERT_W     = 6;
  localparam int TALLY_W    = 6;
  localparam int VC_W       = 7;
  localparam int RANK_W     = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [RANK_W-1:0]  RANK_MAX  = 3'd7;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 6'd63;
  localparam logic [VC_W-1:0]    VERTEX_COUNT_RESET = 7'd64;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_UNION,
    ST_BUMP,
    ST_FINISH
  } kef_state_t;

endpackage

// ===== src/kef_ifs.sv =====
interface kef_edge_if;
  import kef_pkg::*;

  logic              valid;
  logic              ready;
  logic              new_graph;
  logic [VERT_W-1:0] vert_a;
  logic [VERT_W-1:0] vert_b;

  modport source (output valid, new_graph, vert_a, vert_b, input ready);
  modport sink (input valid, new_graph, vert_a, vert_b, output ready);
endinterface

interface kef_result_if;
  import kef_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic [TALLY_W-1:0] tree_edges;

  modport source (output valid, accepted, tree_edges, input ready);
  modport sink (input valid, accepted, tree_edges, output ready);
endinterface

// ===== src/kruskal_edge_filter_top.sv =====
// Spanning-tree edge filter on a disjoint-set table.
// The edges channel carries one edge per beat: new_graph, vert_a and vert_b.
// Edges are expected in non-decreasing weight order. The verdicts channel
// returns one beat per edge: accepted, and tree_edges, the count after it.
// vertex_count is written over the APB port at byte address 0 (any address with paddr[2] low) and is read back.
// A single-port set table is walked by a small sequencer: every parent hop
// is a table read, then a compare, once to find a root and once more to
// point each visited entry straight at it. A join of two sets of equal rank
// adds a rank-bump step. The verdict becomes valid, and the edges channel
// ready again, in the same cycle. An edge out of range skips the table walk.
// A finished verdict waits in an output register; while the receiver stalls,
// the next edge may be taken and worked on, but its verdict is held back
// until the register frees up.
// Reset empties the set table (each vertex its own set, rank zero), clears
// the count, sets vertex_count to 64 and drops valid on the verdicts channel.
// new_graph does the same to the table and the count, but not to vertex_count.
`include "kruskal_edge_filter_top_macros.svh"

module kruskal_edge_filter_top #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  kef_edge_if.sink                        edges,
  kef_result_if.source                    verdicts,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kef_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [kef_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [kef_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import kef_pkg::*;

  localparam int unsigned DEPTH = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int IW = $clog2(DEPTH);
  localparam int WW = RANK_W + IW;

  kef_state_t state, state_next;

  logic [VC_W-1:0]    vertex_count;
  logic [IW-1:0]      cur, cur_next;
  logic               sel_b, sel_b_next;
  logic [IW-1:0]      a_idx, a_idx_next;
  logic [IW-1:0]      b_idx, b_idx_next;
  logic [IW-1:0]      ra, ra_next;
  logic [IW-1:0]      rb, rb_next;
  logic [RANK_W-1:0]  rank_a, rank_a_next;
  logic [RANK_W-1:0]  rank_b, rank_b_next;
  logic               acc, acc_next;
  logic [TALLY_W-1:0] edge_tally, edge_tally_next;
  logic               out_valid, out_valid_next;
  logic               out_accepted;
  logic [TALLY_W-1:0] out_tree_edges;
  logic               out_load;
  logic               clear_table;

  logic [WW-1:0]      table_mem [DEPTH];
  logic [DEPTH-1:0]   entry_valid;
  logic [WW-1:0]      rd_word;
  logic               rd_vld;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [WW-1:0]      mem_wdata;

  logic [IW-1:0]      parent_eff;
  logic [RANK_W-1:0]  rank_eff;
  logic [IW-1:0]      root_cur;
  logic               in_range;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (psel && penable && pwrite &&
                 paddr[CFG_ADDR_W-1] == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[VC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1] == REG_VERTEX_COUNT) begin
      prdata = CFG_DATA_W'(vertex_count);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_word <= table_mem[cur];
    rd_vld  <= entry_valid[cur];
  end

  always_ff @(posedge clk) begin
    if (rst || clear_table) begin
      entry_valid <= '0;
    end else if (mem_we) begin
      entry_valid[mem_waddr] <= 1'b1;
    end
  end

  assign parent_eff = rd_vld ? rd_word[IW-1:0] : cur;
  assign rank_eff   = rd_vld ? rd_word[WW-1:IW] : '0;
  assign root_cur   = sel_b ? rb : ra;

  assign in_range = ({1'b0, edges.vert_a} < vertex_count) &&
                    ({1'b0, edges.vert_b} < vertex_count) &&
                    (32'(edges.vert_a) < MAX_VERTICES) &&
                    (32'(edges.vert_b) < MAX_VERTICES);

  assign edges.ready        = (state == ST_IDLE);
  assign verdicts.valid     = out_valid;
  assign verdicts.accepted  = out_accepted;
  assign verdicts.tree_edges = out_tree_edges;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      edge_tally <= '0;
      out_valid  <= 1'b0;
      sel_b      <= 1'b0;
    end else begin
      state      <= state_next;
      edge_tally <= edge_tally_next;
      out_valid  <= out_valid_next;
      sel_b      <= sel_b_next;
    end
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    a_idx  <= a_idx_next;
    b_idx  <= b_idx_next;
    ra     <= ra_next;
    rb     <= rb_next;
    rank_a <= rank_a_next;
    rank_b <= rank_b_next;
    acc    <= acc_next;
    if (out_load) begin
      out_accepted   <= acc;
      out_tree_edges <= edge_tally;
    end
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    sel_b_next      = sel_b;
    a_idx_next      = a_idx;
    b_idx_next      = b_idx;
    ra_next         = ra;
    rb_next         = rb;
    rank_a_next     = rank_a;
    rank_b_next     = rank_b;
    acc_next        = acc;
    edge_tally_next = edge_tally;
    clear_table     = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = cur;
    mem_wdata       = '0;
    out_load        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (edges.valid) begin
          if (edges.new_graph) begin
            clear_table     = 1'b1;
            edge_tally_next = '0;
          end
          a_idx_next = edges.vert_a[IW-1:0];
          b_idx_next = edges.vert_b[IW-1:0];
          cur_next   = edges.vert_a[IW-1:0];
          sel_b_next = 1'b0;
          acc_next   = 1'b0;
          state_next = in_range ? ST_FIND_RD : ST_FINISH;
        end
      end
      ST_FIND_RD: begin
        state_next = ST_FIND_CHK;
      end
      ST_FIND_CHK: begin
        if (parent_eff == cur) begin
          if (sel_b) begin
            rb_next     = cur;
            rank_b_next = rank_eff;
            cur_next    = b_idx;
          end else begin
            ra_next     = cur;
            rank_a_next = rank_eff;
            cur_next    = a_idx;
          end
          state_next = ST_CMP_RD;
        end else begin
          cur_next   = parent_eff;
          state_next = ST_FIND_RD;
        end
      end
      ST_CMP_RD: begin
        if (cur == root_cur) begin
          if (sel_b) begin
            state_next = ST_UNION;
          end else begin
            sel_b_next = 1'b1;
            cur_next   = b_idx;
            state_next = ST_FIND_RD;
          end
        end else begin
          state_next = ST_CMP_CHK;
        end
      end
      ST_CMP_CHK: begin
        mem_we     = 1'b1;
        mem_waddr  = cur;
        mem_wdata  = {rank_eff, root_cur};
        cur_next   = parent_eff;
        state_next = ST_CMP_RD;
      end
      ST_UNION: begin
        state_next = ST_FINISH;
        if (ra != rb) begin
          acc_next = 1'b1;
          if (edge_tally != TALLY_MAX) begin
            edge_tally_next = edge_tally + 1'b1;
          end
          mem_we = 1'b1;
          if (rank_a < rank_b) begin
            mem_waddr = ra;
            mem_wdata = {rank_a, rb};
          end else begin
            mem_waddr = rb;
            mem_wdata = {rank_b, ra};
            if (rank_a == rank_b) begin
              state_next = ST_BUMP;
            end
          end
        end
      end
      ST_BUMP: begin
        mem_we    = 1'b1;
        mem_waddr = ra;
        mem_wdata = {(rank_a != RANK_MAX) ? rank_a + 1'b1 : rank_a, ra};
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || verdicts.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next = (out_valid && !verdicts.ready) || out_load;
  end

  `KEF_ASSERT_SAME(a_accept_counts, verdicts.valid && verdicts.accepted, verdicts.tree_edges != '0)
  `KEF_ASSERT_NEXT(a_tally_holds, state != ST_UNION && !(edges.valid && edges.ready), $stable(edge_tally))
  `KEF_ASSERT_SAME(a_idle_no_write, state == ST_IDLE || state == ST_FINISH, !mem_we)

endmodule

// ===== test/kruskal_edge_filter_top_test.sv =====
module kruskal_edge_filter_top_test;
  import kef_pkg::*;

  localparam int VERTS = 64;
  localparam int EDGE_GOAL = 950;
  localparam int CALM_TAIL = 100;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [CFG_ADDR_W-1:0] VC_ADDR = CFG_ADDR_W'(4 * int'(REG_VERTEX_COUNT));

  typedef struct packed {
    logic               accepted;
    logic [TALLY_W-1:0] tree_edges;
  } verdict_t;

  class forest_tracker;
    logic [VERT_W-1:0]  parent_vtx [VERTS];
    logic [RANK_W-1:0]  rank_vtx [VERTS];
    logic [TALLY_W-1:0] tally;
    logic [VC_W-1:0]    vertex_count;
    verdict_t           pending_verdicts [$];
    int                 errors;
    int                 checked;
    int                 joins;
    int                 resets;
    int                 top_tally;

    function new();
      clear_forest();
      vertex_count = VERTEX_COUNT_RESET;
    endfunction

    function void clear_forest();
      for (int i = 0; i < VERTS; i++) begin
        parent_vtx[i] = VERT_W'(i);
        rank_vtx[i] = '0;
      end
      tally = '0;
    endfunction

    function void set_vertex_count(logic [VC_W-1:0] value);
      vertex_count = value;
    endfunction

    // Walks up to the root, then points every entry on the path at it.
    function logic [VERT_W-1:0] find_root(logic [VERT_W-1:0] v);
      logic [VERT_W-1:0] r;
      logic [VERT_W-1:0] nxt;
      int hops;
      r = v;
      hops = 0;
      while (parent_vtx[r] != r && hops < VERTS) begin
        r = parent_vtx[r];
        hops++;
      end
      hops = 0;
      while (v != r && hops < VERTS) begin
        nxt = parent_vtx[v];
        parent_vtx[v] = r;
        v = nxt;
        hops++;
      end
      return r;
    endfunction

    function void note_edge(logic ng, logic [VERT_W-1:0] a, logic [VERT_W-1:0] b);
      logic [VERT_W-1:0] ra;
      logic [VERT_W-1:0] rb;
      verdict_t v;
      v.accepted = 1'b0;
      if (ng) begin
        clear_forest();
        resets++;
      end
      if ({1'b0, a} < vertex_count && {1'b0, b} < vertex_count) begin
        ra = find_root(a);
        rb = find_root(b);
        if (ra != rb) begin
          v.accepted = 1'b1;
          if (rank_vtx[ra] < rank_vtx[rb]) begin
            parent_vtx[ra] = rb;
          end else if (rank_vtx[ra] > rank_vtx[rb]) begin
            parent_vtx[rb] = ra;
          end else begin
            parent_vtx[rb] = ra;
            if (rank_vtx[ra] != RANK_MAX) rank_vtx[ra]++;
          end
          if (tally != TALLY_MAX) tally++;
        end
      end
      v.tree_edges = tally;
      if (int'(tally) > top_tally) top_tally = int'(tally);
      pending_verdicts = {pending_verdicts, v};
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("edge filter mismatch: %s", msg);
      errors++;
    endtask

    task check_verdict(logic accepted, logic [TALLY_W-1:0] tree_edges);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("verdict with nothing expected (accepted=%0b tree_edges=%0d)",
                         accepted, tree_edges));
      end else begin
        want = pending_verdicts.pop_front();
        checked++;
        if (want.accepted) joins++;
        if (accepted !== want.accepted)
          report($sformatf("verdict %0d: accepted %0b, expected %0b",
                           checked, accepted, want.accepted));
        if (tree_edges !== want.tree_edges)
          report($sformatf("verdict %0d: tree_edges %0d, expected %0d",
                           checked, tree_edges, want.tree_edges));
      end
    endtask

    task flush_leftovers();
      while (pending_verdicts.size() != 0) begin
        void'(pending_verdicts.pop_front());
        report("expected verdict never arrived");
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  kef_edge_if edge_ch ();
  kef_result_if verdict_ch ();

  forest_tracker sb = new();
  bit idle_on = 1'b1;
  int sent = 0;
  int cfg_writes = 0;
  int quiet = 0;

  kruskal_edge_filter_top DUT (
    .clk      (clk),
    .rst      (rst),
    .edges    (edge_ch),
    .verdicts (verdict_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Verdict sink: checks each beat and stalls in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        verdict_ch.ready <= 1'b0;
      end else begin
        if (verdict_ch.valid && verdict_ch.ready)
          sb.check_verdict(verdict_ch.accepted, verdict_ch.tree_edges);
        if (stall_left > 0) begin
          stall_left--;
          verdict_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 13) - 1;
          verdict_ch.ready <= 1'b0;
        end else begin
          verdict_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (edge_ch.valid && edge_ch.ready) ||
        (verdict_ch.valid && verdict_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d verdicts outstanding",
               QUIET_LIMIT, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_edge(input logic ng, input logic [VERT_W-1:0] a,
                           input logic [VERT_W-1:0] b);
    if (sent >= EDGE_GOAL - CALM_TAIL) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      edge_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    edge_ch.valid <= 1'b1;
    edge_ch.new_graph <= ng;
    edge_ch.vert_a <= a;
    edge_ch.vert_b <= b;
    do @(posedge clk); while (!edge_ch.ready);
    sb.note_edge(ng, a, b);
    sent++;
  endtask

  task automatic wait_idle();
    edge_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= VC_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_vertex_count(value[VC_W-1:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [VERT_W-1:0] pick_vertex(int nv);
    if (nv == 0) return VERT_W'($urandom_range(0, VERTS - 1));
    return VERT_W'($urandom_range(0, nv - 1));
  endfunction

  initial begin
    int vc;
    int nv;
    int m;
    int j;
    bit first_phase;
    logic [VERT_W-1:0] perm [VERTS];
    logic [VERT_W-1:0] tmp;
    logic [VERT_W-1:0] a;
    logic [VERT_W-1:0] b;

    rst <= 1'b1;
    edge_ch.valid <= 1'b0;
    edge_ch.new_graph <= 1'b0;
    edge_ch.vert_a <= '0;
    edge_ch.vert_b <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed edges at the reset vertex_count, then small and odd counts.
    send_edge(1'b1, 6'd0, 6'd63);
    send_edge(1'b0, 6'd63, 6'd0);
    send_edge(1'b0, 6'd5, 6'd5);
    send_edge(1'b0, 6'd1, 6'd2);
    send_edge(1'b0, 6'd3, 6'd4);
    send_edge(1'b0, 6'd1, 6'd3);
    send_edge(1'b0, 6'd2, 6'd4);
    send_edge(1'b0, 6'd0, 6'd1);
    send_edge(1'b0, 6'd62, 6'd61);
    send_edge(1'b0, 6'd60, 6'd59);
    send_edge(1'b0, 6'd62, 6'd60);
    send_edge(1'b0, 6'd4, 6'd61);
    send_edge(1'b0, 6'd59, 6'd2);
    wait_idle();
    write_vertex_count(32'd10);
    send_edge(1'b1, 6'd9, 6'd0);
    send_edge(1'b0, 6'd10, 6'd3);
    send_edge(1'b0, 6'd3, 6'd63);
    send_edge(1'b1, 6'd12, 6'd40);
    send_edge(1'b0, 6'd9, 6'd8);
    wait_idle();
    write_vertex_count(32'd2);
    send_edge(1'b1, 6'd0, 6'd1);
    send_edge(1'b0, 6'd1, 6'd0);
    send_edge(1'b0, 6'd2, 6'd0);
    wait_idle();
    write_vertex_count(32'd0);
    send_edge(1'b0, 6'd0, 6'd0);
    send_edge(1'b1, 6'd1, 6'd1);
    wait_idle();
    write_vertex_count(32'd1);
    send_edge(1'b0, 6'd0, 6'd0);
    wait_idle();
    write_vertex_count(32'hA5A5_A5FF);
    send_edge(1'b1, 6'd63, 6'd0);
    send_edge(1'b0, 6'd62, 6'd63);

    // Random graphs: mostly well-formed edge streams with some noise.
    first_phase = 1'b1;
    while (sent < EDGE_GOAL) begin
      if (first_phase) begin
        vc = VERTS;
      end else begin
        case ($urandom_range(0, 9))
          0: vc = VERTS;
          1: vc = $urandom_range(0, 1) ? $urandom_range(65, 127) : $urandom_range(0, 1);
          default: vc = $urandom_range(2, 16);
        endcase
      end
      wait_idle();
      write_vertex_count(CFG_DATA_W'(vc));
      nv = (vc > VERTS) ? VERTS : vc;
      repeat ($urandom_range(1, 3)) begin
        if (sent >= EDGE_GOAL) break;
        idle_on = (sent < EDGE_GOAL - CALM_TAIL) && ($urandom_range(0, 3) != 0);
        if (nv >= 2 && (first_phase || $urandom_range(0, 2) == 0)) begin
          // A full spanning tree in shuffled order, padded with random extra edges.
          for (int i = 0; i < VERTS; i++) perm[i] = VERT_W'(i);
          for (int i = nv - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
          for (int i = 1; i < nv; i++) begin
            a = perm[$urandom_range(0, i - 1)];
            b = perm[i];
            if ($urandom_range(0, 1)) send_edge(i == 1, a, b);
            else send_edge(i == 1, b, a);
            if ($urandom_range(0, 2) == 0) send_edge(1'b0, pick_vertex(nv), pick_vertex(nv));
          end
        end else begin
          m = $urandom_range(1, 2 * nv + 2);
          for (int i = 0; i < m; i++) begin
            if ($urandom_range(0, 11) == 0) begin
              a = VERT_W'($urandom_range(0, VERTS - 1));
              b = VERT_W'($urandom_range(0, VERTS - 1));
            end else begin
              a = pick_vertex(nv);
              b = pick_vertex(nv);
            end
            send_edge(i == 0 || $urandom_range(0, 29) == 0, a, b);
          end
        end
        first_phase = 1'b0;
      end
    end

    idle_on = 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    sb.flush_leftovers();
    $display("Ran %0d edges under %0d vertex_count writes; %0d verdicts checked, %0d joins.",
             sent, cfg_writes, sb.checked, sb.joins);
    $display("Forest cleared %0d times; largest tree_edges seen %0d.",
             sb.resets, sb.top_tally);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
